// ----- hw/rtl/shtp_pkg.sv -----
// shared types, constants and name functions for the symbol hash table probe
`timescale 1ns / 1ps

package shtp_pkg;

    localparam int TABLE_DEPTH_DEF = 2048;
    localparam int NAME_BYTES_DEF  = 8;

    localparam int CFG_W   = 12;
    localparam int KEY_W   = 16;
    localparam int NAME_W  = 64;
    localparam int TYPE_W  = 5;
    localparam int VALUE_W = 16;
    localparam int SLOT_W  = 11;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 12'd1553;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEPS = 2;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic {
        DIV_SEL_KEY,
        DIV_SEL_QP1
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     calc_key;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_start;
        logic     take_step;
        logic     adv;
        logic     latch;
        logic     latch_full;
        logic     wr;
        logic     clr_step;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic step_zero;
        logic occ;
        logic match;
        logic n_at_size;
        logic insert;
    } status_t;

    // zero every byte after the first nul and at or beyond nbytes
    function automatic logic [NAME_W-1:0] name_norm(input logic [NAME_W-1:0] raw,
                                                    input int nbytes);
        logic [NAME_W-1:0] res;
        logic              alive;
        res   = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i >= nbytes || raw[8*i +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

    // add each byte up to the first nul, swapping the key bytes after each add
    function automatic logic [KEY_W-1:0] name_key(input logic [NAME_W-1:0] nm);
        logic [KEY_W-1:0] key;
        logic             alive;
        key   = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (nm[8*i +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                key = key + KEY_W'(nm[8*i +: 8]);
                key = {key[7:0], key[15:8]};
            end
        end
        return key;
    endfunction

endpackage

// ----- hw/rtl/shtp_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module shtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/shtp_div.sv -----
// iterative restoring divider for the 16-bit key, DIV_STEPS quotient bits per cycle
`timescale 1ns / 1ps

module shtp_div #(
    parameter int DIVISOR_W = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [shtp_pkg::KEY_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]       divisor,
    output logic                       done,
    output logic [shtp_pkg::KEY_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]       remainder
);

    localparam int ITER = shtp_pkg::KEY_W / shtp_pkg::DIV_STEPS;
    localparam int CW   = (ITER > 1) ? $clog2(ITER) : 1;

    logic                       active_reg;
    logic                       done_reg;
    logic [CW-1:0]              cnt_reg;
    logic [shtp_pkg::KEY_W-1:0] quo_reg;
    logic [shtp_pkg::KEY_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]       rem_reg;
    logic [DIVISOR_W-1:0]       rem_next;

    always_comb
    begin
        logic [DIVISOR_W:0]         r;
        logic [shtp_pkg::KEY_W-1:0] q;
        r = {1'b0, rem_reg};
        q = quo_reg;
        for (int i = 0; i < shtp_pkg::DIV_STEPS; i++)
        begin
            r = {r[DIVISOR_W-1:0], q[shtp_pkg::KEY_W-1]};
            q = {q[shtp_pkg::KEY_W-2:0], 1'b0};
            if (r >= {1'b0, divisor})
            begin
                r    = r - {1'b0, divisor};
                q[0] = 1'b1;
            end
        end
        rem_next = r[DIVISOR_W-1:0];
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(ITER - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/shtp_datapath.sv -----
// datapath: size register, key, divider, probe index walk, entry ram and result registers
`timescale 1ns / 1ps

module shtp_datapath #(
    parameter int TABLE_DEPTH = shtp_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = shtp_pkg::NAME_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  shtp_pkg::cmd_t               cmd,
    output shtp_pkg::status_t            status,
    input  logic                         cfg_wr_en,
    input  logic [shtp_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                         action,
    input  logic [shtp_pkg::NAME_W-1:0]  sym_name,
    input  logic [shtp_pkg::TYPE_W-1:0]  sym_type,
    input  logic [shtp_pkg::VALUE_W-1:0] sym_value,
    output logic                         found,
    output logic [shtp_pkg::SLOT_W-1:0]  slot,
    output logic [shtp_pkg::TYPE_W-1:0]  out_type,
    output logic [shtp_pkg::VALUE_W-1:0] out_value,
    output logic                         full_res
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int SIZE_MAX = (TABLE_DEPTH < 4095) ? TABLE_DEPTH : 4095;
    localparam int SW       = $clog2(SIZE_MAX + 1);
    localparam int PW       = ((AW > SW) ? AW : SW) + 1;
    localparam int WORD_W   = 1 + shtp_pkg::TYPE_W + shtp_pkg::VALUE_W + shtp_pkg::NAME_W;
    localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

    logic [shtp_pkg::CFG_W-1:0]   size_cfg_reg;
    logic                         action_reg;
    logic [shtp_pkg::NAME_W-1:0]  name_reg;
    logic [shtp_pkg::TYPE_W-1:0]  type_reg;
    logic [shtp_pkg::VALUE_W-1:0] value_reg;
    logic [SW-1:0]                size_reg;
    logic [SW-1:0]                size_next;
    logic [shtp_pkg::KEY_W-1:0]   key_reg;
    logic [shtp_pkg::KEY_W-1:0]   qp1_reg;
    logic [SW-1:0]                step_reg;
    logic [AW-1:0]                idx_reg;
    logic [AW-1:0]                idx_next;
    logic [SW-1:0]                n_reg;
    logic [AW-1:0]                clr_reg;

    logic                         found_reg;
    logic [shtp_pkg::SLOT_W-1:0]  slot_reg;
    logic [shtp_pkg::TYPE_W-1:0]  otype_reg;
    logic [shtp_pkg::VALUE_W-1:0] ovalue_reg;
    logic                         full_reg;

    logic [shtp_pkg::KEY_W-1:0]   div_dividend;
    logic                         div_done;
    logic [shtp_pkg::KEY_W-1:0]   div_quo;
    logic [SW-1:0]                div_rem;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [WORD_W-1:0]            ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [WORD_W-1:0]            ram_rdata;

    logic                         occ;
    logic                         match;
    logic                         stop;
    logic [PW-1:0]                idx_w;
    logic [PW-1:0]                step_w;
    logic [PW-1:0]                size_w;

    // size clamped into 2 .. table depth
    always_comb
    begin
        if (size_cfg_reg < shtp_pkg::CFG_W'(2))
        begin
            size_next = SW'(2);
        end
        else if (17'(size_cfg_reg) > DEPTH17)
        begin
            size_next = SW'(DEPTH17);
        end
        else
        begin
            size_next = SW'(size_cfg_reg);
        end
    end

    // downward step with wrap
    assign idx_w  = PW'(idx_reg);
    assign step_w = PW'(step_reg);
    assign size_w = PW'(size_reg);

    always_comb
    begin
        if (idx_w >= step_w)
        begin
            idx_next = AW'(idx_w - step_w);
        end
        else
        begin
            idx_next = AW'(idx_w + size_w - step_w);
        end
    end

    assign div_dividend = (cmd.div_sel == shtp_pkg::DIV_SEL_KEY) ? key_reg : qp1_reg;

    shtp_div #(
        .DIVISOR_W (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (size_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // entry word: occupied, type, value, name
    assign ram_we    = cmd.clr_step | cmd.wr;
    assign ram_waddr = cmd.clr_step ? clr_reg : idx_reg;
    assign ram_wdata = cmd.clr_step ? '0 : {1'b1, type_reg, value_reg, name_reg};
    assign ram_raddr = idx_next;

    shtp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.adv),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign occ   = ram_rdata[WORD_W-1];
    assign match = occ && (ram_rdata[shtp_pkg::NAME_W-1:0] == name_reg);
    assign stop  = !occ || match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= shtp_pkg::TABLE_SIZE_RESET;
            clr_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_cfg_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            name_reg   <= shtp_pkg::name_norm(sym_name, NAME_BYTES);
            type_reg   <= sym_type;
            value_reg  <= sym_value;
            size_reg   <= size_next;
        end
        if (cmd.calc_key)
        begin
            key_reg <= shtp_pkg::name_key(name_reg);
        end
        if (cmd.take_start)
        begin
            idx_reg <= AW'(PW'(div_rem));
            qp1_reg <= div_quo + shtp_pkg::KEY_W'(1);
            n_reg   <= '0;
        end
        if (cmd.take_step)
        begin
            step_reg <= div_rem;
        end
        if (cmd.adv)
        begin
            idx_reg <= idx_next;
            n_reg   <= n_reg + SW'(1);
        end
        if (cmd.latch)
        begin
            found_reg <= !cmd.latch_full && match;
            full_reg  <= cmd.latch_full || !stop;
            slot_reg  <= shtp_pkg::SLOT_W'(idx_reg);
            if (!cmd.latch_full && match)
            begin
                otype_reg  <= ram_rdata[shtp_pkg::NAME_W + shtp_pkg::VALUE_W +: shtp_pkg::TYPE_W];
                ovalue_reg <= ram_rdata[shtp_pkg::NAME_W +: shtp_pkg::VALUE_W];
            end
            else
            begin
                otype_reg  <= '0;
                ovalue_reg <= '0;
            end
        end
    end

    assign status.clr_last  = (clr_reg == AW'(TABLE_DEPTH - 1));
    assign status.div_done  = div_done;
    assign status.step_zero = (step_reg == '0);
    assign status.occ       = occ;
    assign status.match     = match;
    assign status.n_at_size = (n_reg == size_reg);
    assign status.insert    = (action_reg == shtp_pkg::ACT_INSERT);

    assign found     = found_reg;
    assign slot      = slot_reg;
    assign out_type  = otype_reg;
    assign out_value = ovalue_reg;
    assign full_res  = full_reg;

endmodule

// ----- hw/rtl/shtp_ctrl.sv -----
// controller state machine: clearing pass, key, two divisions, probe walk
`timescale 1ns / 1ps

module shtp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output shtp_pkg::cmd_t    cmd,
    input  shtp_pkg::status_t status
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_DIV_KEY_GO,
        ST_DIV_KEY_WAIT,
        ST_DIV_STEP_GO,
        ST_DIV_STEP_WAIT,
        ST_STEP_TEST,
        ST_ADV,
        ST_CHK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = shtp_pkg::DIV_SEL_KEY;
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                cmd.calc_key = 1'b1;
                state_next   = ST_DIV_KEY_GO;
            end
            ST_DIV_KEY_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_KEY_WAIT;
            end
            ST_DIV_KEY_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.take_start = 1'b1;
                    state_next     = ST_DIV_STEP_GO;
                end
            end
            ST_DIV_STEP_GO:
            begin
                cmd.div_sel   = shtp_pkg::DIV_SEL_QP1;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_STEP_WAIT;
            end
            ST_DIV_STEP_WAIT:
            begin
                cmd.div_sel = shtp_pkg::DIV_SEL_QP1;
                if (status.div_done)
                begin
                    cmd.take_step = 1'b1;
                    state_next    = ST_STEP_TEST;
                end
            end
            ST_STEP_TEST:
            begin
                if (status.step_zero)
                begin
                    cmd.latch      = 1'b1;
                    cmd.latch_full = 1'b1;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                cmd.adv    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (!status.occ || status.match)
                begin
                    cmd.latch  = 1'b1;
                    cmd.wr     = status.insert;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.n_at_size)
                begin
                    cmd.latch  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ADV;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/symbol_hash_table_probe.sv -----
// top level of the symbol hash table probe engine
`timescale 1ns / 1ps

// symbol table engine, open addressing with double hashing. a transfer is
// taken on a rising edge with start high and busy low; the result shows on
// found/slot/out_type/out_value/full_res, marked by done for exactly one cycle,
// and cannot be held off: capture it when done is high. the result
// ports keep their value until the next result. after reset the block
// clears all TABLE_DEPTH entries of its entry memory (2048 by default), one
// entry per cycle; busy stays high for that time. table_size may be written
// whenever the block is idle and takes effect with the next item.
//
// an item passes the key step, then two divisions by the table size, for
// start slot and probe step, then the step check; each probe then takes an
// advance state and a check state, set by the registered read of the entry
// memory, before the return to idle. a zero probe step ends at the step check
// with full_res set.
module symbol_hash_table_probe #(
    parameter int TABLE_DEPTH = shtp_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = shtp_pkg::NAME_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // command side
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [shtp_pkg::NAME_W-1:0]  sym_name,
    input  logic [shtp_pkg::TYPE_W-1:0]  sym_type,
    input  logic [shtp_pkg::VALUE_W-1:0] sym_value,
    // table size register
    input  logic                         cfg_wr_en,
    input  logic [shtp_pkg::CFG_W-1:0]   cfg_wr_data,
    // result side
    output logic                         done,
    output logic                         found,
    output logic [shtp_pkg::SLOT_W-1:0]  slot,
    output logic [shtp_pkg::TYPE_W-1:0]  out_type,
    output logic [shtp_pkg::VALUE_W-1:0] out_value,
    output logic                         full_res
);

    // commands from the controller, status back from the datapath
    shtp_pkg::cmd_t    cmd;
    shtp_pkg::status_t status;

    shtp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // key, divider, probe walk, entry memory and result registers
    shtp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .action      (action),
        .sym_name    (sym_name),
        .sym_type    (sym_type),
        .sym_value   (sym_value),
        .found       (found),
        .slot        (slot),
        .out_type    (out_type),
        .out_value   (out_value),
        .full_res    (full_res)
    );

endmodule

// ----- dv/symbol_hash_table_probe_tb.sv -----
// self-checking testbench for the symbol hash table probe engine
`timescale 1ns / 1ps

module symbol_hash_table_probe_tb;

    import shtp_pkg::*;

    localparam int    CLK_HALF     = 6;
    localparam int    RESET_CYCLES = 9;
    // slowest legal item: full walk of 2048 slots, plus setup,
    // plus the longest sender gap; the entry clear after reset comes on top
    localparam int    SLOW_ITEM    = 32 + 2 * TABLE_DEPTH_DEF + 64;
    localparam int    MAX_ITEMS    = 900;
    localparam int    CYCLE_LIMIT  = 4 * (TABLE_DEPTH_DEF + MAX_ITEMS * SLOW_ITEM);
    localparam int    DRAIN_CYCLES = 64;
    localparam int    MAX_REPORTS  = 200;
    localparam int    POOL_N       = 48;
    localparam int    N_PHASES     = 12;

    typedef struct {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [TYPE_W-1:0]  sym_type;
        logic [VALUE_W-1:0] sym_value;
        logic               full;
    } probe_result_t;

    // mirror of the hash table plus the queue of probe results still to come
    class symtab_mirror;
        int unsigned        size_reg;
        bit                 occ[TABLE_DEPTH_DEF];
        logic [NAME_W-1:0]  slot_name[TABLE_DEPTH_DEF];
        logic [TYPE_W-1:0]  slot_type[TABLE_DEPTH_DEF];
        logic [VALUE_W-1:0] slot_value[TABLE_DEPTH_DEF];
        probe_result_t      expected_probes[$];
        int                 fails;
        int                 items;
        int                 hits;
        int                 fulls;
        int                 stores;

        function new();
            size_reg = 32'(TABLE_SIZE_RESET);
            foreach (occ[i])
            begin
                occ[i] = 1'b0;
            end
            fails  = 0;
            items  = 0;
            hits   = 0;
            fulls  = 0;
            stores = 0;
        endfunction

        function void set_size(int unsigned v);
            size_reg = v;
        endfunction

        function int pending();
            return expected_probes.size();
        endfunction

        // keep bytes up to the first nul, zero the rest
        function logic [NAME_W-1:0] canon_name(logic [NAME_W-1:0] raw);
            logic [NAME_W-1:0] nm;
            int                len;
            nm  = '0;
            len = 0;
            while (len < 8 && raw[8*len +: 8] != 8'd0)
            begin
                nm[8*len +: 8] = raw[8*len +: 8];
                len++;
            end
            return nm;
        endfunction

        function logic [KEY_W-1:0] hash_key(logic [NAME_W-1:0] nm);
            logic [KEY_W-1:0] k;
            int               i;
            k = '0;
            i = 0;
            while (i < 8 && nm[8*i +: 8] != 8'd0)
            begin
                k = k + {8'd0, nm[8*i +: 8]};
                k = {k[7:0], k[15:8]};
                i++;
            end
            return k;
        endfunction

        function void predict_probe(logic act, logic [NAME_W-1:0] raw,
                                    logic [TYPE_W-1:0] typ, logic [VALUE_W-1:0] val);
            logic [NAME_W-1:0] nm;
            int unsigned       key;
            int unsigned       sz;
            int unsigned       idx;
            int unsigned       stp;
            int unsigned       n;
            bit                hit;
            bit                stopped;
            probe_result_t     r;
            nm  = canon_name(raw);
            key = 32'(hash_key(nm));
            sz  = size_reg;
            if (sz < 2)
            begin
                sz = 2;
            end
            if (sz > TABLE_DEPTH_DEF)
            begin
                sz = TABLE_DEPTH_DEF;
            end
            idx     = key % sz;
            stp     = (key / sz + 1) % sz;
            hit     = 1'b0;
            stopped = 1'b0;
            n       = 0;
            if (stp != 0)
            begin
                while (!stopped && n < sz)
                begin
                    idx = (idx >= stp) ? idx - stp : idx + sz - stp;
                    if (!occ[idx])
                    begin
                        stopped = 1'b1;
                    end
                    else if (slot_name[idx] == nm)
                    begin
                        stopped = 1'b1;
                        hit     = 1'b1;
                    end
                    n++;
                end
            end
            r.found     = hit;
            r.slot      = SLOT_W'(idx);
            r.sym_type  = hit ? slot_type[idx] : '0;
            r.sym_value = hit ? slot_value[idx] : '0;
            r.full      = !stopped;
            expected_probes.push_back(r);
            items++;
            if (hit)
            begin
                hits++;
            end
            if (!stopped)
            begin
                fulls++;
            end
            if (stopped && act == ACT_INSERT)
            begin
                occ[idx]        = 1'b1;
                slot_name[idx]  = nm;
                slot_type[idx]  = typ;
                slot_value[idx] = val;
                stores++;
            end
        endfunction

        function void compare_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                begin
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, what, exp_v, act_v);
                end
            end
        endfunction

        function void check_probe(logic f, logic [SLOT_W-1:0] s, logic [TYPE_W-1:0] t,
                                  logic [VALUE_W-1:0] v, logic fr);
            probe_result_t e;
            if (expected_probes.size() == 0)
            begin
                fails++;
                $display("%0t: result with no transfer pending, expected none, actual slot %0h",
                         $time, s);
                return;
            end
            e = expected_probes.pop_front();
            compare_field("found", 64'(e.found), 64'(f));
            compare_field("slot", 64'(e.slot), 64'(s));
            compare_field("out_type", 64'(e.sym_type), 64'(t));
            compare_field("out_value", 64'(e.sym_value), 64'(v));
            compare_field("full_res", 64'(e.full), 64'(fr));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               action;
    logic [NAME_W-1:0]  sym_name;
    logic [TYPE_W-1:0]  sym_type;
    logic [VALUE_W-1:0] sym_value;
    logic               cfg_wr_en;
    logic [CFG_W-1:0]   cfg_wr_data;
    logic               done;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [TYPE_W-1:0]  out_type;
    logic [VALUE_W-1:0] out_value;
    logic               full_res;

    symtab_mirror       sb;
    int                 cycle_count = 0;

    // names that come back again and again so that hits and overwrites happen
    logic [NAME_W-1:0]  name_pool[POOL_N];

    // table sizes for the random phases: the tiny ones fill up and hit zero steps,
    // out-of-range writes check the clamp at both ends
    int unsigned phase_size[N_PHASES]  = '{2, 0, 1, 3, 7, 13, 31, 4095, 2048, 97, 1553, 2049};
    int          phase_items[N_PHASES] = '{40, 20, 20, 40, 60, 60, 80, 100, 120, 80, 190, 40};

    symbol_hash_table_probe uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .sym_name    (sym_name),
        .sym_type    (sym_type),
        .sym_value   (sym_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .found       (found),
        .slot        (slot),
        .out_type    (out_type),
        .out_value   (out_value),
        .full_res    (full_res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // results cannot be held off, so every done cycle is one transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_probe(found, slot, out_type, out_value, full_res);
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // nonzero bytes up to len, zero above
    function automatic logic [NAME_W-1:0] fresh_name(int len);
        logic [NAME_W-1:0] nm;
        nm = '0;
        for (int i = 0; i < len; i++)
        begin
            nm[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        return nm;
    endfunction

    // present one item and hold it until the block takes it
    task automatic push_item(input logic act, input logic [NAME_W-1:0] nm,
                             input logic [TYPE_W-1:0] typ, input logic [VALUE_W-1:0] val);
        start     <= 1'b1;
        action    <= act;
        sym_name  <= nm;
        sym_type  <= typ;
        sym_value <= val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.predict_probe(act, nm, typ, val);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // nothing in flight and the walk finished
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_size(input int unsigned v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(v);
        sb.set_size(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic push_random();
        logic [NAME_W-1:0] nm;
        int                r;
        int                len;
        int                i;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            nm = name_pool[$urandom_range(0, POOL_N - 1)];
            // junk after the terminator must still match the stored name
            if ($urandom_range(0, 3) == 0)
            begin
                len = 0;
                while (len < 8 && nm[8*len +: 8] != 8'd0)
                begin
                    len++;
                end
                for (i = len + 1; i < 8; i++)
                begin
                    nm[8*i +: 8] = 8'($urandom);
                end
            end
        end
        else if (r < 90)
        begin
            nm = fresh_name($urandom_range(0, 8));
            name_pool[$urandom_range(0, POOL_N - 1)] = nm;
        end
        else
        begin
            // raw noise, cut at whatever byte happens to be zero
            nm = {$urandom, $urandom};
        end
        push_item(1'($urandom_range(0, 1)), nm, TYPE_W'($urandom), VALUE_W'($urandom));
    endtask

    // bursts of back-to-back transfers with gaps of varying length in between;
    // long gaps let the block finish and sit idle, short ones land mid-walk
    task automatic random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
            while (burst > 0 && sent < count)
            begin
                push_random();
                burst--;
                sent++;
            end
            idle_for(($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12));
        end
    endtask

    initial
    begin
        sb = new();
        start       <= 1'b0;
        action      <= ACT_LOOKUP;
        sym_name    <= '0;
        sym_type    <= '0;
        sym_value   <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        rst_n       <= 1'b0;
        foreach (name_pool[i])
        begin
            name_pool[i] = fresh_name($urandom_range(1, 8));
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset size; the first transfer waits out the clear
        push_item(ACT_LOOKUP, 64'h41, 5'd0, 16'd0);                       // empty table miss
        push_item(ACT_INSERT, 64'h41, 5'd31, 16'hFFFF);                   // first insert, max payload
        push_item(ACT_LOOKUP, 64'h41, 5'd0, 16'd0);                       // hit
        idle_for(3);
        push_item(ACT_INSERT, 64'h41, 5'd0, 16'd0);                       // overwrite shows old payload
        push_item(ACT_LOOKUP, 64'h41, 5'd0, 16'd0);
        push_item(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 5'd21, 16'hA5A5);  // full eight byte name
        push_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 16'd0);
        idle_for(30);
        push_item(ACT_INSERT, 64'h4142, 5'd10, 16'h5A5A);
        push_item(ACT_LOOKUP, 64'hDEAD_BEEF_0000_4142, 5'd0, 16'd0);      // junk past the nul
        push_item(ACT_INSERT, 64'h0000_1234_0043_4241, 5'd3, 16'h0001);
        push_item(ACT_LOOKUP, 64'h0043_4241, 5'd0, 16'd0);
        push_item(ACT_LOOKUP, 64'h0, 5'd0, 16'd0);                        // empty name miss
        push_item(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 5'd5, 16'd1);      // empty name after nul
        push_item(ACT_LOOKUP, 64'h0, 5'd0, 16'd0);
        settle();

        // two-slot table: zero step, fill it, then a walk that finds no room
        write_size(2);
        push_item(ACT_INSERT, 64'h0102, 5'd7, 16'h1234);                  // step wraps to zero
        push_item(ACT_INSERT, 64'h0, 5'd1, 16'h0002);
        push_item(ACT_INSERT, 64'h41, 5'd2, 16'h0003);
        push_item(ACT_LOOKUP, 64'h42, 5'd0, 16'd0);                       // both slots taken
        push_item(ACT_INSERT, 64'h42, 5'd31, 16'hFFFF);                   // full, nothing written
        push_item(ACT_LOOKUP, 64'h41, 5'd0, 16'd0);
        settle();

        // random phases, one table size each, written only while idle
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_size(phase_size[p]);
            random_phase(phase_items[p]);
            settle();
        end

        // a stray result would still turn up in this window
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d transfers across %0d table size settings",
                 sb.items, N_PHASES + 2);
        $display("%0d hits, %0d walks ended full or on a zero step, %0d entries written",
                 sb.hits, sb.fulls, sb.stores);
        if (sb.fails == 0 && sb.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
